// ===== rtl/core/cisd_pkg.sv =====
// ----------------------------------------------------------------------------
// cisd_pkg - shared types and codes of the compressed integer decoder
// Decode kinds, status codes, length codes and the event that the byte
// collector hands to the formatting stage.
// ----------------------------------------------------------------------------
`default_nettype none

package cisd_pkg;

  // Decode kind, sampled on the lead byte; kind 3 is handled as unsigned
  localparam logic [1:0] KIND_UNSIGNED = 2'd0;
  localparam logic [1:0] KIND_SIGNED   = 2'd1;
  localparam logic [1:0] KIND_TOKEN    = 2'd2;

  // Result status
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TRUNC   = 2'd1,
    ST_BADLEAD = 2'd2,
    ST_BADTAG  = 2'd3
  } status_e;

  // Encoded length of the value in progress
  localparam logic [1:0] LEN_1 = 2'd0;
  localparam logic [1:0] LEN_2 = 2'd1;
  localparam logic [1:0] LEN_4 = 2'd2;

  // Widest raw value: 5 lead bits plus three continuation bytes
  localparam int unsigned RawW  = 29;
  // Widest partial value held between bytes
  localparam int unsigned CollW = 21;

  // One completed or failed value, as queued between the two halves
  typedef struct packed {
    logic [RawW-1:0] raw;
    logic [1:0]      kind;
    logic [1:0]      len;
    status_e         status;
  } event_t;

endpackage : cisd_pkg

`default_nettype wire

// ===== rtl/core/cisd_front.sv =====
// ----------------------------------------------------------------------------
// cisd_front - byte collector
// Takes one byte per beat, checks the lead prefix, gathers continuation
// bytes and raises an event when a value completes or fails.
// ----------------------------------------------------------------------------
`default_nettype none

module cisd_front
  import cisd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic [1:0] func_i,
  input  wire logic       range_end_i,
  input  wire logic       q_full_i,
  output logic            push_o,
  output event_t          ev_o
);

  logic [CollW-1:0] coll_q, coll_d;
  logic [1:0]       rem_q, rem_d;
  logic [1:0]       kind_q, kind_d;
  logic [1:0]       len_q, len_d;
  logic [1:0]       rem_dec;
  logic             ev_valid;
  logic             accept;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & in_ready_o;
  assign push_o     = accept & ev_valid;

  // Lead / continuation classification and next state
  always_comb begin
    rem_d     = rem_q;
    coll_d    = coll_q;
    kind_d    = kind_q;
    len_d     = len_q;
    rem_dec   = rem_q - 2'd1;
    ev_valid  = 1'b0;
    ev_o.raw    = {coll_q, data_byte_i};
    ev_o.kind   = kind_q;
    ev_o.len    = len_q;
    ev_o.status = ST_OK;
    if (rem_q == 2'd0) begin
      kind_d    = func_i;
      ev_o.kind = func_i;
      ev_o.raw  = RawW'(data_byte_i);
      priority if (!data_byte_i[7]) begin
        len_d    = LEN_1;
        ev_o.len = LEN_1;
        ev_valid = 1'b1;
      end else if (!data_byte_i[6]) begin
        len_d  = LEN_2;
        rem_d  = 2'd1;
        coll_d = CollW'(data_byte_i[5:0]);
      end else if (!data_byte_i[5]) begin
        len_d  = LEN_4;
        rem_d  = 2'd3;
        coll_d = CollW'(data_byte_i[4:0]);
      end else begin
        ev_valid    = 1'b1;
        ev_o.status = ST_BADLEAD;
        rem_d       = 2'd0;
        coll_d      = '0;
      end
      // truncated right after a multi-byte lead
      if (data_byte_i[7] && !(data_byte_i[6] && data_byte_i[5]) && range_end_i) begin
        ev_valid    = 1'b1;
        ev_o.status = ST_TRUNC;
        rem_d       = 2'd0;
        coll_d      = '0;
      end
    end else begin
      rem_d = rem_dec;
      if (rem_dec == 2'd0) begin
        ev_valid = 1'b1;
        coll_d   = '0;
      end else if (range_end_i) begin
        ev_valid    = 1'b1;
        ev_o.status = ST_TRUNC;
        rem_d       = 2'd0;
        coll_d      = '0;
      end else begin
        coll_d = ev_o.raw[CollW-1:0];
      end
    end
  end

  // State advances on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coll_q <= '0;
      rem_q  <= 2'd0;
      kind_q <= KIND_UNSIGNED;
      len_q  <= LEN_1;
    end else if (accept) begin
      coll_q <= coll_d;
      rem_q  <= rem_d;
      kind_q <= kind_d;
      len_q  <= len_d;
    end
  end

  // A failed value always returns the collector to the lead state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && (ev_o.status != ST_OK)) |=> (rem_q == 2'd0))
    else $error("collector not back at lead after error");

  // A short value never leaves bytes pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (rem_q == 2'd0) && !data_byte_i[7]) |=> (rem_q == 2'd0))
    else $error("single-byte value left bytes pending");

  // Four-byte count is only reached from a lead byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q == 2'd3) |-> (len_q == LEN_4))
    else $error("length code does not match pending count");

endmodule : cisd_front

`default_nettype wire

// ===== rtl/core/cisd_fifo.sv =====
// ----------------------------------------------------------------------------
// cisd_fifo - event queue
// Short queue between the byte collector and the formatting stage so that
// each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module cisd_fifo
  import cisd_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire event_t wdata_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output logic        valid_o,
  output event_t      rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  event_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("pop from empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("fill count missed a push");

endmodule : cisd_fifo

`default_nettype wire

// ===== rtl/core/cisd_back.sv =====
// ----------------------------------------------------------------------------
// cisd_back - result formatter
// Turns a queued event into the final 32-bit pattern and status, held in
// an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cisd_back
  import cisd_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   q_valid_i,
  input  wire event_t q_data_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output logic [31:0] value_o,
  output logic [1:0]  status_o
);

  // Table codes placed in bits 31:24 of a type token
  localparam logic [7:0] CodeTypeDef  = 8'h02;
  localparam logic [7:0] CodeTypeRef  = 8'h01;
  localparam logic [7:0] CodeTypeSpec = 8'h1B;

  localparam logic [31:0] SignMask1 = 32'hFFFF_FFC0;
  localparam logic [31:0] SignMask2 = 32'hFFFF_E000;
  localparam logic [31:0] SignMask4 = 32'hF000_0000;

  logic        valid_q;
  logic [31:0] value_q, value_d;
  status_e     status_q, status_d;
  logic [31:0] sign_mask;
  logic [7:0]  code;

  assign pop_o       = q_valid_i & (~valid_q | out_ready_i);
  assign out_valid_o = valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

  // Sign extension mask by length
  always_comb begin
    unique case (q_data_i.len)
      LEN_1:   sign_mask = SignMask1;
      LEN_2:   sign_mask = SignMask2;
      default: sign_mask = SignMask4;
    endcase
  end

  // Token table lookup
  always_comb begin
    unique case (q_data_i.raw[1:0])
      2'd0:    code = CodeTypeDef;
      2'd1:    code = CodeTypeRef;
      default: code = CodeTypeSpec;
    endcase
  end

  // Final pattern by kind
  always_comb begin
    status_d = q_data_i.status;
    value_d  = 32'(q_data_i.raw);
    if (q_data_i.status != ST_OK) begin
      value_d = '0;
    end else if (q_data_i.kind == KIND_SIGNED) begin
      value_d = 32'(q_data_i.raw[RawW-1:1]) | (q_data_i.raw[0] ? sign_mask : 32'h0);
    end else if (q_data_i.kind == KIND_TOKEN) begin
      if (q_data_i.raw[1:0] == 2'd3) begin
        status_d = ST_BADTAG;
        value_d  = '0;
      end else begin
        value_d = 32'(q_data_i.raw[RawW-1:2]) | {code, 24'h0};
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      value_q  <= value_d;
      status_q <= status_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && (status_q != ST_OK)) |-> (value_q == 32'h0))
    else $error("error result carries a value");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_o |=> valid_q)
    else $error("popped event not presented");

  // A stalled beat stays put until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_ready_i) |=> (valid_q && $stable(value_q) && $stable(status_q)))
    else $error("result changed while stalled");

endmodule : cisd_back

`default_nettype wire

// ===== rtl/core/compressed_integer_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// compressed_integer_stream_decoder - compressed integer decoder top level
// Decodes 1, 2 or 4 byte compressed integers from a signature byte stream.
//
// Input channel: one signature byte per beat (data_byte_i), with the decode
// kind func_i (sampled on lead bytes) and range_end_i marking the last byte
// available. Output channel: one beat per completed or failed value, with
// value_o and status_o (0 ok, 1 truncated, 2 bad lead byte, 3 bad tag).
// Bytes that neither complete nor fail a value give no output beat.
// Throughput: one byte per cycle, sustained, while the output is taken.
// The result of the byte that ends a value passes through the event queue
// and then the output register before it appears on value_o and status_o.
// The byte collector and the formatter are parted by a QueueDepth-entry
// queue; when the receiver stalls the queue fills and in_ready_o drops only
// once it is full. Reset returns the collector to the lead-byte state and
// empties the queue and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module compressed_integer_stream_decoder
  import cisd_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [1:0]  func_i,
  input  wire logic        range_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      value_o,
  output logic [1:0]       status_o
);

  event_t push_ev, head_ev;
  logic   push, pop, q_full, q_valid;

  // Byte collector
  cisd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .func_i      (func_i),
    .range_end_i (range_end_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .ev_o        (push_ev)
  );

  // Event queue
  cisd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_ev),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (head_ev)
  );

  // Result formatter and output register
  cisd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (head_ev),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o),
    .status_o    (status_o)
  );

endmodule : compressed_integer_stream_decoder

`default_nettype wire

// ===== sim/compressed_integer_stream_decoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// compressed_integer_stream_decoder_tb - self-checking bench for the decoder
// Sends signature bytes through the input channel and checks every output
// beat against a decoder model kept in the bench. Directed values cover the
// length and kind extremes, all token tags, bad lead bytes and truncation.
// Random values follow, mostly well formed, with random gaps on both sides
// and long receiver hold-offs that back-pressure the input.
// ----------------------------------------------------------------------------

module compressed_integer_stream_decoder_tb;
  import cisd_pkg::*;

  // Spare decode kind, handled as unsigned
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // Token tags and their table codes
  localparam logic [1:0] TAG_TYPEDEF  = 2'd0;
  localparam logic [1:0] TAG_TYPEREF  = 2'd1;
  localparam logic [1:0] TAG_TYPESPEC = 2'd2;
  localparam logic [7:0] CODE_TYPEDEF  = 8'h02;
  localparam logic [7:0] CODE_TYPEREF  = 8'h01;
  localparam logic [7:0] CODE_TYPESPEC = 8'h1B;

  localparam int unsigned NumRandom   = 900;
  localparam int unsigned HoldCycles  = 150;
  localparam int unsigned MaxReported = 10;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] func;
    logic       last;
  } sig_byte_t;

  typedef struct packed {
    logic [31:0] value;
    status_e     status;
  } decoded_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic [1:0]  func_i      = 2'd0;
  logic        range_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] value_o;
  logic [1:0]  status_o;

  sig_byte_t   byte_backlog[$];
  decoded_t    expected_values[$];

  // Model state of the byte collector
  logic [23:0] coll_bits  = '0;
  logic [1:0]  bytes_left = '0;
  logic [1:0]  lead_kind  = KIND_UNSIGNED;
  logic [1:0]  value_len  = LEN_1;

  int unsigned fail_count = 0;
  int unsigned beats_in   = 0;
  int unsigned next_hold  = 250;
  int unsigned hold_left  = 0;
  int unsigned stall_left = 0;
  int unsigned send_gap   = 0;
  bit          send_quiet = 1'b0;
  bit          recv_quiet = 1'b0;
  logic        in_taken   = 1'b0;

  compressed_integer_stream_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .func_i      (func_i),
    .range_end_i (range_end_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o),
    .status_o    (status_o)
  );

  always #2 clk_i = ~clk_i;

  // Turn a complete raw value into the decoded pattern for its kind
  function automatic decoded_t format_value(logic [31:0] raw, logic [1:0] kind,
                                            logic [1:0] vlen);
    decoded_t res;
    logic [31:0] sext;
    res.value  = raw;
    res.status = ST_OK;
    case (kind)
      KIND_SIGNED: begin
        sext = (vlen == LEN_1) ? 32'hFFFF_FFC0 :
               (vlen == LEN_2) ? 32'hFFFF_E000 : 32'hF000_0000;
        res.value = raw >> 1;
        if (raw[0]) res.value = res.value | sext;
      end
      KIND_TOKEN: begin
        case (raw[1:0])
          TAG_TYPEDEF:  res.value = (raw >> 2) | {CODE_TYPEDEF, 24'h0};
          TAG_TYPEREF:  res.value = (raw >> 2) | {CODE_TYPEREF, 24'h0};
          TAG_TYPESPEC: res.value = (raw >> 2) | {CODE_TYPESPEC, 24'h0};
          default: begin
            res.value  = 32'h0;
            res.status = ST_BADTAG;
          end
        endcase
      end
      default: ;
    endcase
    return res;
  endfunction

  // Advance the model by one accepted byte; queue any result it causes
  task automatic decode_byte(input logic [7:0] b, input logic [1:0] f, input logic e);
    logic [31:0] acc;
    if (bytes_left == 2'd0) begin
      lead_kind = f;
      if (!b[7]) begin
        value_len = LEN_1;
        expected_values.push_back(format_value({24'h0, b}, f, LEN_1));
      end else if (b[7:5] == 3'b111) begin
        expected_values.push_back('{value: 32'h0, status: ST_BADLEAD});
      end else begin
        if (!b[6]) begin
          value_len  = LEN_2;
          coll_bits  = {18'h0, b[5:0]};
          bytes_left = 2'd1;
        end else begin
          value_len  = LEN_4;
          coll_bits  = {19'h0, b[4:0]};
          bytes_left = 2'd3;
        end
        if (e) begin
          expected_values.push_back('{value: 32'h0, status: ST_TRUNC});
          bytes_left = 2'd0;
          coll_bits  = '0;
        end
      end
    end else begin
      acc        = {coll_bits, b};
      bytes_left = bytes_left - 2'd1;
      if (bytes_left == 2'd0) begin
        expected_values.push_back(format_value(acc, lead_kind, value_len));
        coll_bits = '0;
      end else begin
        coll_bits = acc[23:0];
        if (e) begin
          expected_values.push_back('{value: 32'h0, status: ST_TRUNC});
          bytes_left = 2'd0;
          coll_bits  = '0;
        end
      end
    end
  endtask

  // Mostly no gap, some short, a few long
  function automatic int unsigned draw_gap(bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic queue_byte(input logic [7:0] b, input logic [1:0] f, input logic e);
    byte_backlog.push_back('{data: b, func: f, last: e});
  endtask

  // Model update and result check at the rising edge
  always @(posedge clk_i) begin
    decoded_t want;
    if (rst_ni) begin
      in_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        decode_byte(data_byte_i, func_i, range_end_i);
        beats_in <= beats_in + 1;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_values.size() == 0) begin
          if (fail_count < MaxReported)
            $display("unexpected beat: value %08h status %0d", value_o, status_o);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_values.pop_front();
          if (value_o !== want.value || status_o !== want.status) begin
            if (fail_count < MaxReported)
              $display("mismatch: expected value %08h status %0d, got %08h status %0d",
                       want.value, want.status, value_o, status_o);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  // Sender: next byte from the backlog after the current beat is taken
  always @(negedge clk_i) begin
    sig_byte_t nxt;
    logic      nv;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      nv = 1'b0;
      if ($urandom_range(0, 99) == 0) send_quiet = !send_quiet;
      if (send_gap != 0) begin
        send_gap = send_gap - 1;
      end else if (byte_backlog.size() != 0) begin
        nxt = byte_backlog.pop_front();
        nv  = 1'b1;
        data_byte_i <= nxt.data;
        func_i      <= nxt.func;
        range_end_i <= nxt.last;
        send_gap = draw_gap(send_quiet);
      end
      in_valid_i <= nv;
    end
  end

  // Receiver: random stalls plus long hold-offs to fill the decoder
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (beats_in >= next_hold) begin
        hold_left = HoldCycles;
        next_hold = next_hold + 400;
      end
      if ($urandom_range(0, 99) == 0) recv_quiet = !recv_quiet;
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_ready_i <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left = stall_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        stall_left = draw_gap(recv_quiet);
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int unsigned nb;
    int unsigned cut_at;
    logic [1:0]  kind;
    logic [7:0]  b;
    logic [1:0]  f;
    logic        e;

    // Directed: length and kind extremes
    queue_byte(8'h00, KIND_UNSIGNED, 1'b0);
    queue_byte(8'h7F, KIND_SIGNED, 1'b0);
    queue_byte(8'h80, KIND_TOKEN, 1'b0);
    queue_byte(8'h00, KIND_UNSIGNED, 1'b0);
    // range end on the completing byte is fine
    queue_byte(8'hBF, KIND_SIGNED, 1'b0);
    queue_byte(8'hFF, KIND_UNSIGNED, 1'b1);
    queue_byte(8'hC0, KIND_TOKEN, 1'b0);
    queue_byte(8'h00, KIND_UNSIGNED, 1'b0);
    queue_byte(8'h00, KIND_UNSIGNED, 1'b0);
    queue_byte(8'h01, KIND_UNSIGNED, 1'b0);
    queue_byte(8'hDF, KIND_SIGNED, 1'b0);
    queue_byte(8'hFF, KIND_SPARE, 1'b0);
    queue_byte(8'hFF, KIND_SPARE, 1'b0);
    queue_byte(8'hFF, KIND_SPARE, 1'b0);
    // bad token tag, type spec tag, spare kind
    queue_byte(8'h03, KIND_TOKEN, 1'b0);
    queue_byte(8'h42, KIND_TOKEN, 1'b0);
    queue_byte(8'h7E, KIND_SPARE, 1'b0);
    // bad lead bytes, with and without range end
    queue_byte(8'hE0, KIND_UNSIGNED, 1'b1);
    queue_byte(8'hFF, KIND_SIGNED, 1'b0);
    // truncation on a lead byte and in the middle of a value
    queue_byte(8'h80, KIND_UNSIGNED, 1'b1);
    queue_byte(8'hC1, KIND_SIGNED, 1'b0);
    queue_byte(8'h23, KIND_UNSIGNED, 1'b1);

    // Random: mostly well formed values, some truncated, some noise
    while (byte_backlog.size() < NumRandom + 22) begin
      if ($urandom_range(0, 99) < 85) begin
        case ($urandom_range(0, 2))
          0:       nb = 1;
          1:       nb = 2;
          default: nb = 4;
        endcase
        kind   = ($urandom_range(0, 9) == 0) ? KIND_SPARE : 2'($urandom_range(0, 2));
        cut_at = (nb > 1 && $urandom_range(0, 19) == 0) ? $urandom_range(0, nb - 2) : nb;
        for (int i = 0; i < nb; i++) begin
          b = 8'($urandom);
          if (i == 0) begin
            case (nb)
              1:       b[7]   = 1'b0;
              2:       b[7:6] = 2'b10;
              default: b[7:5] = 3'b110;
            endcase
          end
          // func only matters on the lead byte
          f = (i == 0) ? kind : 2'($urandom);
          e = (i == nb - 1) ? 1'($urandom) : (i == cut_at);
          queue_byte(b, f, e);
          if (e && i != nb - 1) break;
        end
      end else begin
        queue_byte(8'($urandom), 2'($urandom), $urandom_range(0, 3) == 0);
      end
    end

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    while (byte_backlog.size() != 0 || in_valid_i || expected_values.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (fail_count == 0)
      $display("compressed_integer_stream_decoder regression: pass");
    else
      $display("compressed_integer_stream_decoder regression: fail");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("compressed_integer_stream_decoder regression: fail");
    $finish;
  end

endmodule
